>>> rtl/core/tlvp_pkg.sv
package tlvp_pkg;

    localparam int unsigned ScaleMax  = 127;
    localparam int unsigned MagBits   = 23;
    localparam int unsigned QBits     = 7;
    localparam int unsigned TBits     = 50;
    localparam int unsigned MBits     = 49;
    localparam int unsigned SqBits    = 46;
    localparam int unsigned SumBits   = 48;
    localparam int unsigned RBits     = 60;
    localparam int unsigned PBits     = 62;
    localparam int unsigned QsBits    = 56;

    localparam logic [1:0] REG_LIGHT_X  = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y  = 2'd1;
    localparam logic [1:0] REG_LIGHT_Z  = 2'd2;
    localparam logic [1:0] REG_IS_POINT = 2'd3;

    localparam logic [23:0] DEGEN_WORD = 24'h7F7F7F;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] mat_00;
        logic signed [15:0] mat_01;
        logic signed [15:0] mat_02;
        logic signed [15:0] mat_10;
        logic signed [15:0] mat_11;
        logic signed [15:0] mat_12;
        logic signed [15:0] mat_20;
        logic signed [15:0] mat_21;
        logic signed [15:0] mat_22;
    } in_item_t;

    typedef struct packed {
        logic [23:0] light_word;
        logic        degenerate;
    } out_item_t;

    typedef struct packed {
        logic signed [TBits-1:0] x;
        logic signed [TBits-1:0] y;
        logic signed [TBits-1:0] z;
    } tvec_t;

    // state of the per-component square-root style search
    typedef struct packed {
        logic                       valid;
        logic                       degen;
        logic [2:0]                 neg;
        logic [SumBits-1:0]         s;
        logic [2:0][RBits-1:0]      r;
        logic [2:0][PBits-1:0]      p;
        logic [2:0][QsBits-1:0]     qs;
        logic [2:0][QBits-1:0]      q;
    } iter_t;

endpackage

>>> rtl/core/tlvp_front.sv
module tlvp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  tlvp_pkg::in_item_t    in_item,
    input  logic signed [31:0]    light_x,
    input  logic signed [31:0]    light_y,
    input  logic signed [31:0]    light_z,
    input  logic                  light_is_point,
    output logic                  t_valid,
    output tlvp_pkg::tvec_t       t_vec
);

    logic signed [31:0] l_reg [3];
    logic signed [31:0] l_next [3];
    logic signed [15:0] m_reg [9];
    logic signed [47:0] prod_reg [9];
    tlvp_pkg::tvec_t    t_reg;
    logic               v1_reg, v2_reg, v3_reg;

    logic signed [31:0] light [3];
    logic signed [31:0] pos [3];

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31])
            sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sat_sub = d[31:0];
    endfunction

    assign light[0] = light_x;
    assign light[1] = light_y;
    assign light[2] = light_z;
    assign pos[0]   = in_item.pos_x;
    assign pos[1]   = in_item.pos_y;
    assign pos[2]   = in_item.pos_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            l_next[i] = light_is_point ? sat_sub(light[i], pos[i]) : light[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i] <= l_next[i];
            end
            m_reg[0] <= in_item.mat_00;
            m_reg[1] <= in_item.mat_01;
            m_reg[2] <= in_item.mat_02;
            m_reg[3] <= in_item.mat_10;
            m_reg[4] <= in_item.mat_11;
            m_reg[5] <= in_item.mat_12;
            m_reg[6] <= in_item.mat_20;
            m_reg[7] <= in_item.mat_21;
            m_reg[8] <= in_item.mat_22;
            // row r of the matrix multiplies component r of the light vector
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= l_reg[i / 3] * m_reg[i];
            end
            t_reg.x <= 50'(prod_reg[0]) + 50'(prod_reg[3]) + 50'(prod_reg[6]);
            t_reg.y <= 50'(prod_reg[1]) + 50'(prod_reg[4]) + 50'(prod_reg[7]);
            t_reg.z <= 50'(prod_reg[2]) + 50'(prod_reg[5]) + 50'(prod_reg[8]);
        end
    end

    assign t_valid = v3_reg;
    assign t_vec   = t_reg;

endmodule

>>> rtl/core/tlvp_norm.sv
module tlvp_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                t_valid,
    input  tlvp_pkg::tvec_t     t_vec,
    output tlvp_pkg::iter_t     init
);

    logic [tlvp_pkg::MBits-1:0]  mag_reg [3];
    logic [tlvp_pkg::MBits-1:0]  mag_next [3];
    logic [4:0]                  k_next;
    logic [tlvp_pkg::MBits-1:0]  or_all;
    logic [tlvp_pkg::MagBits-1:0] a_reg [3];
    logic [tlvp_pkg::SqBits-1:0] sq_reg [3];
    logic [2:0]                  neg4_reg, neg5_reg, neg6_reg, neg_next;
    logic                        dg4_reg, dg5_reg, dg6_reg;
    logic                        v4_reg, v5_reg, v6_reg;
    logic signed [tlvp_pkg::TBits-1:0] t [3];
    tlvp_pkg::iter_t             init_reg;

    assign t[0] = t_vec.x;
    assign t[1] = t_vec.y;
    assign t[2] = t_vec.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = t[i][tlvp_pkg::TBits-1] ? 49'(-t[i]) : 49'(t[i]);
        end
        // z is packed negated
        neg_next = {~t[2][tlvp_pkg::TBits-1], t[1][tlvp_pkg::TBits-1],
                    t[0][tlvp_pkg::TBits-1]};
    end

    // shift so that every magnitude fits below 2^23
    always_comb
    begin
        or_all = mag_reg[0] | mag_reg[1] | mag_reg[2];
        k_next = 5'd0;
        for (int i = tlvp_pkg::MagBits; i < tlvp_pkg::MBits; i++)
        begin
            if (or_all[i])
                k_next = 5'(i - tlvp_pkg::MagBits + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            init_reg <= '0;
        end
        else if (en)
        begin
            v4_reg <= t_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            init_reg.valid <= v6_reg;
            init_reg.degen <= dg6_reg;
            init_reg.neg   <= neg6_reg;
            init_reg.s     <= 48'(sq_reg[0]) + 48'(sq_reg[1]) + 48'(sq_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                init_reg.r[i]  <= 60'(sq_reg[i]) * 60'(tlvp_pkg::ScaleMax * tlvp_pkg::ScaleMax);
                init_reg.p[i]  <= '0;
                init_reg.qs[i] <= '0;
                init_reg.q[i]  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_next[i];
                a_reg[i]   <= 23'(mag_reg[i] >> k_next);
                sq_reg[i]  <= 46'(a_reg[i]) * 46'(a_reg[i]);
            end
            neg4_reg <= neg_next;
            dg4_reg  <= (t_vec.x == '0) && (t_vec.y == '0) && (t_vec.z == '0);
            neg5_reg <= neg4_reg;
            dg5_reg  <= dg4_reg;
            neg6_reg <= neg5_reg;
            dg6_reg  <= dg5_reg;
        end
    end

    assign init = init_reg;

endmodule

>>> rtl/core/tlvp_step.sv
module tlvp_step #(
    parameter int unsigned BIT = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  tlvp_pkg::iter_t  cur,
    output tlvp_pkg::iter_t  nxt
);

    tlvp_pkg::iter_t              nxt_reg, nxt_next;
    logic [tlvp_pkg::PBits-1:0]   cand [3];

    // (q+b)^2*s = q^2*s + 2*b*(q*s) + b^2*s, kept as running sums
    always_comb
    begin
        nxt_next = cur;
        for (int i = 0; i < 3; i++)
        begin
            cand[i] = cur.p[i]
                    + (62'(cur.qs[i]) << (BIT + 1))
                    + (62'(cur.s) << (2 * BIT));
            if (cand[i] <= 62'(cur.r[i]))
            begin
                nxt_next.p[i]      = cand[i];
                nxt_next.qs[i]     = cur.qs[i] + (56'(cur.s) << BIT);
                nxt_next.q[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nxt_reg <= '0;
        else if (en)
            nxt_reg <= nxt_next;
    end

    assign nxt = nxt_reg;

endmodule

>>> rtl/core/tangent_light_vector_packer.sv
// tangent-space light vector packer
// items arrive on in_valid/in_stall/in_item: vertex position (q16.16) and
// its 3x3 tangent matrix (q2.14). each item gives one result on
// out_valid/out_stall/out_item: the normalised light vector packed as
// x, negated z, y, each biased by 127, plus a flag for a zero vector.
// light position or direction and the point/directional mode are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// item is in flight, as the block itself does not enforce it.
// the pipeline has 15 register stages: three form the light vector and the
// matrix product, four find the common shift and the squared length, seven
// resolve the 7-bit scale one bit each, one packs.
// throughput is one item per cycle unless the receiver stalls. the whole
// pipeline advances together; when the receiver stalls with a result
// waiting, every stage holds and in_stall rises in the same cycle, so
// nothing is lost or repeated.
// reset clears the light registers to zero, directional mode, and empties
// the pipeline.
module tangent_light_vector_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tlvp_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output tlvp_pkg::out_item_t   out_item
);

    logic signed [31:0]    light_x_reg, light_y_reg, light_z_reg;
    logic                  is_point_reg;
    logic                  en;
    logic                  t_valid;
    tlvp_pkg::tvec_t       t_vec;
    tlvp_pkg::iter_t       chain [tlvp_pkg::QBits + 1];
    tlvp_pkg::iter_t       last;
    logic                  out_valid_reg;
    tlvp_pkg::out_item_t   out_item_reg, out_item_next;
    logic [7:0]            comp [3];

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg  <= '0;
            light_y_reg  <= '0;
            light_z_reg  <= '0;
            is_point_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlvp_pkg::REG_LIGHT_X:  light_x_reg  <= cfg_data;
                tlvp_pkg::REG_LIGHT_Y:  light_y_reg  <= cfg_data;
                tlvp_pkg::REG_LIGHT_Z:  light_z_reg  <= cfg_data;
                tlvp_pkg::REG_IS_POINT: is_point_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tlvp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .in_item        (in_item),
        .light_x        (light_x_reg),
        .light_y        (light_y_reg),
        .light_z        (light_z_reg),
        .light_is_point (is_point_reg),
        .t_valid        (t_valid),
        .t_vec          (t_vec)
    );

    tlvp_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .t_valid (t_valid),
        .t_vec   (t_vec),
        .init    (chain[0])
    );

    for (genvar g = 0; g < tlvp_pkg::QBits; g++)
    begin : g_step
        tlvp_step #(
            .BIT (tlvp_pkg::QBits - 1 - g)
        ) u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cur   (chain[g]),
            .nxt   (chain[g + 1])
        );
    end

    assign last = chain[tlvp_pkg::QBits];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = last.neg[i] ? 8'(tlvp_pkg::ScaleMax) - {1'b0, last.q[i]}
                                  : 8'(tlvp_pkg::ScaleMax) + {1'b0, last.q[i]};
        end
        out_item_next.degenerate = last.degen;
        out_item_next.light_word = last.degen ? tlvp_pkg::DEGEN_WORD
                                              : {comp[0], comp[2], comp[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> sim/tb_tangent_light_vector_packer.sv
module tb_tangent_light_vector_packer;

    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned HoldCycles = 80;
    localparam int unsigned DrainCycles = 30;

    class light_word_board;
        logic signed [31:0] lx_reg;
        logic signed [31:0] ly_reg;
        logic signed [31:0] lz_reg;
        logic               point_mode;
        tlvp_pkg::out_item_t pending_words[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        degen_seen;

        function new();
            lx_reg = '0;
            ly_reg = '0;
            lz_reg = '0;
            point_mode = 1'b0;
            errors = 0;
            checked = 0;
            degen_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                tlvp_pkg::REG_LIGHT_X:  lx_reg = data;
                tlvp_pkg::REG_LIGHT_Y:  ly_reg = data;
                tlvp_pkg::REG_LIGHT_Z:  lz_reg = data;
                tlvp_pkg::REG_IS_POINT: point_mode = data[0];
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned abs_of(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        // largest q with q*q*s <= 127*127*a*a
        function logic [7:0] unit_scale(longint unsigned a, longint unsigned s);
            longint unsigned rhs;
            longint unsigned q;
            rhs = 127 * 127 * a * a;
            q = 127;
            while (q > 0 && q * q * s > rhs)
                q--;
            return q[7:0];
        endfunction

        function logic [7:0] bias(longint t, logic [7:0] q, bit flip);
            bit neg;
            neg = (t < 0) != flip;
            return neg ? 8'd127 - q : 8'd127 + q;
        endfunction

        function void note_vertex(tlvp_pkg::in_item_t it);
            longint lx, ly, lz, tx, ty, tz;
            longint unsigned ax, ay, az, s;
            tlvp_pkg::out_item_t w;
            lx = lx_reg;
            ly = ly_reg;
            lz = lz_reg;
            if (point_mode)
            begin
                lx = sat32(lx - longint'(it.pos_x));
                ly = sat32(ly - longint'(it.pos_y));
                lz = sat32(lz - longint'(it.pos_z));
            end
            tx = lx * longint'(it.mat_00) + ly * longint'(it.mat_10) + lz * longint'(it.mat_20);
            ty = lx * longint'(it.mat_01) + ly * longint'(it.mat_11) + lz * longint'(it.mat_21);
            tz = lx * longint'(it.mat_02) + ly * longint'(it.mat_12) + lz * longint'(it.mat_22);
            if (tx == 0 && ty == 0 && tz == 0)
            begin
                w.light_word = tlvp_pkg::DEGEN_WORD;
                w.degenerate = 1'b1;
            end
            else
            begin
                ax = abs_of(tx);
                ay = abs_of(ty);
                az = abs_of(tz);
                while (((ax | ay | az) >> 23) != 0)
                begin
                    ax >>= 1;
                    ay >>= 1;
                    az >>= 1;
                end
                s = ax * ax + ay * ay + az * az;
                w.light_word = {bias(tx, unit_scale(ax, s), 1'b0),
                                bias(tz, unit_scale(az, s), 1'b1),
                                bias(ty, unit_scale(ay, s), 1'b0)};
                w.degenerate = 1'b0;
            end
            pending_words.push_back(w);
        endfunction

        function void check_word(tlvp_pkg::out_item_t got);
            tlvp_pkg::out_item_t want;
            checked++;
            if (got.degenerate)
                degen_seen++;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h/%b", got.light_word, got.degenerate);
                return;
            end
            want = pending_words.pop_front();
            if (got.light_word !== want.light_word || got.degenerate !== want.degenerate)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected word %h degen %b, got word %h degen %b",
                             want.light_word, want.degenerate, got.light_word, got.degenerate);
            end
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    tlvp_pkg::in_item_t  in_item;
    logic        out_valid;
    logic        out_stall;
    tlvp_pkg::out_item_t out_item;

    light_word_board board;
    int unsigned idle_cycles;
    int unsigned sent;
    bit          hold_req;
    bit          no_gaps;

    tangent_light_vector_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // monitors: everything is sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_vertex(in_item);
            if (out_valid && !out_stall)
                board.check_word(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IdleLimit)
            @(posedge clk);
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("** tangent_light_vector_packer: FAILED **");
        $finish;
    end

    // result side: random stall per item, plus one long hold-off on request
    initial
    begin
        int unsigned n;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 4);
            repeat (n)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_vertex(tlvp_pkg::in_item_t it);
        int unsigned n;
        n = no_gaps ? 0 : $urandom_range(0, 4);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic load_light(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic pt);
        settle();
        write_reg(tlvp_pkg::REG_LIGHT_X, x);
        write_reg(tlvp_pkg::REG_LIGHT_Y, y);
        write_reg(tlvp_pkg::REG_LIGHT_Z, z);
        write_reg(tlvp_pkg::REG_IS_POINT, {31'd0, pt});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic tlvp_pkg::in_item_t make_vertex(tlvp_pkg::in_item_t base,
                                                       logic signed [15:0] m00,
                                                       logic signed [15:0] m11,
                                                       logic signed [15:0] m22);
        tlvp_pkg::in_item_t it;
        it = base;
        it.mat_00 = m00;
        it.mat_01 = '0;
        it.mat_02 = '0;
        it.mat_10 = '0;
        it.mat_11 = m11;
        it.mat_12 = '0;
        it.mat_20 = '0;
        it.mat_21 = '0;
        it.mat_22 = m22;
        return it;
    endfunction

    function automatic tlvp_pkg::in_item_t random_vertex();
        tlvp_pkg::in_item_t it;
        int unsigned kind;
        it = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom});
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: ;  // full range everywhere
            3, 4:
            begin
                // nearby vertices with moderate tangent frames
                it.pos_x = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                it.pos_y = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                it.pos_z = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                it.mat_00 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
                it.mat_11 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
                it.mat_22 = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
                it.mat_01 = $signed(16'($urandom_range(0, 511))) - 16'sd256;
                it.mat_12 = $signed(16'($urandom_range(0, 511))) - 16'sd256;
                it.mat_20 = $signed(16'($urandom_range(0, 511))) - 16'sd256;
            end
            5:
            begin
                it.pos_x = edge_word();
                it.pos_y = edge_word();
                it.pos_z = edge_word();
            end
            6:
            begin
                // vertex at the light: zero vector in point mode
                it.pos_x = board.lx_reg;
                it.pos_y = board.ly_reg;
                it.pos_z = board.lz_reg;
            end
            7:
            begin
                it.mat_00 = '0; it.mat_01 = '0; it.mat_02 = '0;
                it.mat_10 = '0; it.mat_11 = '0; it.mat_12 = '0;
                it.mat_20 = '0; it.mat_21 = '0; it.mat_22 = '0;
                if ($urandom_range(0, 1))
                    it.mat_11 = 16'sh4000;
            end
            8:
                it = make_vertex(it, $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000,
                                 $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000,
                                 $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000);
            default:
            begin
                it.mat_00 = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                it.mat_12 = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
                it.mat_21 = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            end
        endcase
        return it;
    endfunction

    initial
    begin
        tlvp_pkg::in_item_t v;
        board = new();
        idle_cycles = 0;
        sent = 0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        cfg_we = 1'b0;
        cfg_index = tlvp_pkg::REG_LIGHT_X;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset state: zero light, every vertex degenerate
        v = make_vertex('0, 16'sh4000, 16'sh4000, 16'sh4000);
        send_vertex(v);
        send_vertex(random_vertex());

        load_light(32'h0001_0000, 32'h0, 32'h0, 1'b0);
        send_vertex(v);
        send_vertex(make_vertex(v, -16'sh4000, 16'sh4000, 16'sh4000));
        send_vertex(make_vertex(v, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        v.mat_00 = '0;
        v.mat_02 = 16'sh4000;
        send_vertex(v);
        v.mat_02 = -16'sh4000;
        send_vertex(v);
        send_vertex('0);

        load_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        v = '1;
        v.mat_00 = -16'sh8000; v.mat_01 = -16'sh8000; v.mat_02 = -16'sh8000;
        v.mat_10 = -16'sh8000; v.mat_11 = -16'sh8000; v.mat_12 = -16'sh8000;
        v.mat_20 = -16'sh8000; v.mat_21 = -16'sh8000; v.mat_22 = -16'sh8000;
        send_vertex(v);
        v = make_vertex(v, 16'sh7FFF, -16'sh8000, 16'sh0001);
        send_vertex(v);

        // point mode with saturating differences
        load_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        v.pos_x = 32'h8000_0000;
        v.pos_y = 32'h7FFF_FFFF;
        v.pos_z = 32'h8000_0000;
        send_vertex(v);
        v.pos_x = 32'h7FFF_FFFF;
        v.pos_y = 32'h8000_0000;
        v.pos_z = 32'h7FFF_FFFF;
        send_vertex(v);
        v.pos_z = 32'h0;
        send_vertex(v);
        v.pos_x = 32'hFFFF_FFFF;
        send_vertex(v);

        // random phases across several light settings
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_light($urandom, $urandom, $urandom, 1'b0);
                1: load_light(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1);
                2: load_light(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
                3: load_light(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
                4: load_light(edge_word(), edge_word(), edge_word(), 1'b1);
                default: load_light($urandom, $urandom, $urandom, 1'b1);
            endcase
            no_gaps = (phase == 2);
            for (int i = 0; i < 222; i++)
            begin
                if (phase == 1 && i == 60)
                    hold_req = 1'b1;
                if (phase == 3 && i == 100)
                    settle();
                if (phase == 4 && i == 50)
                    no_gaps = 1'b1;
                if (phase == 4 && i == 150)
                    no_gaps = 1'b0;
                send_vertex(random_vertex());
            end
        end

        no_gaps = 1'b0;
        settle();
        $display("vertices sent %0d, results checked %0d, zero-length results %0d",
                 sent, board.checked, board.degen_seen);
        $display("directional and point lights, saturating differences, stalls and hold-offs");
        if (board.errors == 0 && board.pending() == 0)
            $display("** tangent_light_vector_packer: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results missing", board.errors, board.pending());
            $display("** tangent_light_vector_packer: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tlvp_pkg.sv
rtl/core/tlvp_front.sv
rtl/core/tlvp_norm.sv
rtl/core/tlvp_step.sv
rtl/core/tangent_light_vector_packer.sv
sim/tb_tangent_light_vector_packer.sv
